// ===== rtl/bql_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the biquad low-pass filter.
// Used by bql_csr, bql_serial_mult and biquad_lowpass_filter; depends on nothing else.
package bql_pkg;

   // Fixed widths of the filter state and the accumulator.
   localparam int DELAY_WIDTH    = 32;
   localparam int EXTRA_FRAC     = 8;
   localparam int ACC_WIDTH      = 64;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic signed [DELAY_WIDTH-1:0] delay_type;
   typedef logic signed [ACC_WIDTH-1:0]   acc_type;
   typedef logic [2:0]                    reg_index_type;
   typedef logic [2:0]                    coef_index_type;
   typedef logic [2:0]                    prod_index_type;

   // Register indexes of the configuration port.
   localparam reg_index_type REG_BYPASS = 3'd0;
   localparam reg_index_type REG_B0     = 3'd1;
   localparam reg_index_type REG_B1     = 3'd2;
   localparam reg_index_type REG_B2     = 3'd3;
   localparam reg_index_type REG_A1     = 3'd4;
   localparam reg_index_type REG_A2     = 3'd5;

   // Slots of the coefficient array.
   localparam int NUM_COEFS = 5;
   localparam coef_index_type COEF_B0 = 3'd0;
   localparam coef_index_type COEF_B1 = 3'd1;
   localparam coef_index_type COEF_B2 = 3'd2;
   localparam coef_index_type COEF_A1 = 3'd3;
   localparam coef_index_type COEF_A2 = 3'd4;

   // Order in which the five products go through the shared multiplier.
   localparam prod_index_type PROD_A1W1 = 3'd0;
   localparam prod_index_type PROD_A2W2 = 3'd1;
   localparam prod_index_type PROD_B0W0 = 3'd2;
   localparam prod_index_type PROD_B1W1 = 3'd3;
   localparam prod_index_type PROD_B2W2 = 3'd4;

   // Saturation limits of the accumulator; the low limit is the negated high limit.
   localparam logic signed [ACC_WIDTH:0] SAT_HI = {2'b00, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH:0] SAT_LO = -SAT_HI;

   // Add two accumulator words and clamp the sum to the symmetric 64-bit range.
   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      logic signed [ACC_WIDTH:0] sum;
      sum = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
      if (sum > SAT_HI) begin
         sum = SAT_HI;
      end else if (sum < SAT_LO) begin
         sum = SAT_LO;
      end
      return sum[ACC_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/bql_csr.sv =====
// Configuration registers of the biquad low-pass filter: bypass flag and five coefficients.
// Depends on bql_pkg for the register indexes and port widths.
module bql_csr #(
   parameter int COEF_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bql_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [bql_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [bql_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output logic                                  bypass,
   output logic [bql_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs
);
   import bql_pkg::*;

   logic                                 bypass_ff;
   logic                                 bypass_in;
   logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_ff;
   logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_in;
   reg_index_type                        index;
   logic                                 write_en;

   assign index    = csr_paddr[4:2];
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   // Write decode; indexes past the last register are dropped.
   always_comb begin
      bypass_in = bypass_ff;
      coef_in   = coef_ff;
      if (write_en) begin
         unique case (index)
            REG_BYPASS: bypass_in        = csr_pwdata[0];
            REG_B0:     coef_in[COEF_B0] = csr_pwdata[COEF_WIDTH-1:0];
            REG_B1:     coef_in[COEF_B1] = csr_pwdata[COEF_WIDTH-1:0];
            REG_B2:     coef_in[COEF_B2] = csr_pwdata[COEF_WIDTH-1:0];
            REG_A1:     coef_in[COEF_A1] = csr_pwdata[COEF_WIDTH-1:0];
            REG_A2:     coef_in[COEF_A2] = csr_pwdata[COEF_WIDTH-1:0];
            default:    bypass_in        = bypass_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b1;
         coef_ff   <= '0;
      end else begin
         bypass_ff <= bypass_in;
         coef_ff   <= coef_in;
      end
   end

   // Read decode; coefficients read back zero-extended.
   always_comb begin
      unique case (index)
         REG_BYPASS: csr_prdata = CSR_DATA_WIDTH'(bypass_ff);
         REG_B0:     csr_prdata = CSR_DATA_WIDTH'(coef_ff[COEF_B0]);
         REG_B1:     csr_prdata = CSR_DATA_WIDTH'(coef_ff[COEF_B1]);
         REG_B2:     csr_prdata = CSR_DATA_WIDTH'(coef_ff[COEF_B2]);
         REG_A1:     csr_prdata = CSR_DATA_WIDTH'(coef_ff[COEF_A1]);
         REG_A2:     csr_prdata = CSR_DATA_WIDTH'(coef_ff[COEF_A2]);
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign bypass     = bypass_ff;
   assign coefs      = coef_ff;

endmodule

// ===== rtl/bql_serial_mult.sv =====
// Bit-serial signed multiplier: one coefficient bit per cycle against a 32-bit delay word.
// Depends on bql_pkg for the delay word width.
module bql_serial_mult #(
   parameter int COEF_WIDTH = 24
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic signed [COEF_WIDTH-1:0]                 coef,
   input  logic signed [bql_pkg::DELAY_WIDTH-1:0]       mcand,
   output logic                                         done,
   output logic signed [COEF_WIDTH+bql_pkg::DELAY_WIDTH-1:0] product
);
   import bql_pkg::*;

   localparam int PROD_WIDTH = COEF_WIDTH + DELAY_WIDTH;
   localparam int CNT_WIDTH  = $clog2(COEF_WIDTH);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic [COEF_WIDTH-1:0]         coef_sr_ff, coef_sr_in;
   delay_type                     mcand_ff, mcand_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic                          last_bit;
   logic signed [DELAY_WIDTH:0]   mcand_ext;
   logic signed [DELAY_WIDTH:0]   addend;
   logic signed [DELAY_WIDTH:0]   upper_sum;

   assign last_bit  = (cnt_ff == '0);
   assign mcand_ext = {mcand_ff[DELAY_WIDTH-1], mcand_ff};

   // The sign bit of the coefficient carries negative weight, so it subtracts.
   always_comb begin
      if (!coef_sr_ff[0]) begin
         addend = '0;
      end else if (last_bit) begin
         addend = -mcand_ext;
      end else begin
         addend = mcand_ext;
      end
      upper_sum = {prod_ff[PROD_WIDTH-1], prod_ff[PROD_WIDTH-1:COEF_WIDTH]} + addend;
   end

   // Shift-and-add step: add into the upper part, then shift the whole product right.
   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      coef_sr_in = coef_sr_ff;
      mcand_in   = mcand_ff;
      prod_in    = prod_ff;
      done_in    = 1'b0;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_WIDTH'(COEF_WIDTH - 1);
         coef_sr_in = coef;
         mcand_in   = mcand;
         prod_in    = '0;
      end else if (busy_ff) begin
         prod_in    = {upper_sum, prod_ff[COEF_WIDTH-1:1]};
         coef_sr_in = coef_sr_ff >> 1;
         cnt_in     = cnt_ff - 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_sr_ff <= coef_sr_in;
      mcand_ff   <= mcand_in;
      prod_ff    <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/biquad_lowpass_filter.sv =====
// Direct form II biquad low-pass filter on one shared bit-serial multiplier.
// Filtered sample: two feedback products, rounding, new w0, three feed-forward products and
// output rounding in order; a new sample is taken only after the result is registered.
// Bypassed sample: valid the cycle after acceptance, one sample per cycle while rsp_ready is high.
// Synchronous active-high reset sets bypass, clears coefficients, delay words and handshakes.
// Depends on bql_pkg, bql_csr and bql_serial_mult.
module biquad_lowpass_filter #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_sample_out,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bql_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [bql_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [bql_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import bql_pkg::*;

   localparam int PROD_WIDTH = COEF_WIDTH + DELAY_WIDTH;
   localparam int FB_SHIFT   = COEF_WIDTH - 2;
   localparam int Y_SHIFT    = FB_SHIFT + EXTRA_FRAC;
   localparam acc_type RND_FB = acc_type'(64'sd1 <<< (FB_SHIFT - 1));
   localparam acc_type RND_Y  = acc_type'(64'sd1 <<< (Y_SHIFT - 1));
   localparam acc_type W_MAX  = acc_type'((64'sd1 <<< (DELAY_WIDTH - 1)) - 64'sd1);
   localparam acc_type W_MIN  = -W_MAX - acc_type'(64'sd1);
   localparam acc_type Y_MAX  = acc_type'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam acc_type Y_MIN  = -Y_MAX - acc_type'(64'sd1);

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL      = 3'd1;
   localparam logic [2:0] S_ROUND_FB = 3'd2;
   localparam logic [2:0] S_W0       = 3'd3;
   localparam logic [2:0] S_ROUND_Y  = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic                                 bypass;
   logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs;

   logic [2:0]                      state_ff, state_in;
   prod_index_type                  prod_ff, prod_in;
   logic                            start_ff, start_in;
   acc_type                         acc_ff, acc_in;
   logic signed [SAMPLE_WIDTH-1:0]  x_ff, x_in;
   delay_type                       w0_ff, w0_in;
   delay_type                       delay_one_ff, delay_one_in;
   delay_type                       delay_two_ff, delay_two_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic                            req_fire;
   logic                            out_free;
   logic signed [COEF_WIDTH-1:0]    mul_coef;
   delay_type                       mul_mcand;
   logic                            mul_done;
   logic signed [PROD_WIDTH-1:0]    mul_product;
   acc_type                         addend;
   acc_type                         acc_sum;
   acc_type                         fb_rounded;
   acc_type                         w0_wide;
   delay_type                       w0_sat;
   acc_type                         y_wide;
   logic signed [SAMPLE_WIDTH-1:0]  y_sat;

   bql_csr #(
      .COEF_WIDTH(COEF_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .bypass     (bypass),
      .coefs      (coefs)
   );

   // Operand select for the product in flight.
   always_comb begin
      unique case (prod_ff)
         PROD_A1W1: begin
            mul_coef  = coefs[COEF_A1];
            mul_mcand = delay_one_ff;
         end
         PROD_A2W2: begin
            mul_coef  = coefs[COEF_A2];
            mul_mcand = delay_two_ff;
         end
         PROD_B0W0: begin
            mul_coef  = coefs[COEF_B0];
            mul_mcand = w0_ff;
         end
         PROD_B1W1: begin
            mul_coef  = coefs[COEF_B1];
            mul_mcand = delay_one_ff;
         end
         PROD_B2W2: begin
            mul_coef  = coefs[COEF_B2];
            mul_mcand = delay_two_ff;
         end
         default: begin
            mul_coef  = '0;
            mul_mcand = '0;
         end
      endcase
   end

   bql_serial_mult #(
      .COEF_WIDTH(COEF_WIDTH)
   ) u_mult (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .coef   (mul_coef),
      .mcand  (mul_mcand),
      .done   (mul_done),
      .product(mul_product)
   );

   // Shared saturating accumulator: adds a finished product or a rounding constant.
   always_comb begin
      if (state_ff == S_ROUND_FB) begin
         addend = RND_FB;
      end else if (state_ff == S_ROUND_Y) begin
         addend = RND_Y;
      end else begin
         addend = ACC_WIDTH'(mul_product);
      end
      acc_sum = sat_add(acc_ff, addend);
   end

   // New delay word: scaled sample minus rounded feedback, clamped to 32 bits.
   always_comb begin
      fb_rounded = acc_ff >>> FB_SHIFT;
      w0_wide    = (ACC_WIDTH'(x_ff) <<< EXTRA_FRAC) - fb_rounded;
      if (w0_wide > W_MAX) begin
         w0_sat = W_MAX[DELAY_WIDTH-1:0];
      end else if (w0_wide < W_MIN) begin
         w0_sat = W_MIN[DELAY_WIDTH-1:0];
      end else begin
         w0_sat = w0_wide[DELAY_WIDTH-1:0];
      end
   end

   // Output sample: rounded sum shifted down and clamped to the sample width.
   always_comb begin
      y_wide = acc_ff >>> Y_SHIFT;
      if (y_wide > Y_MAX) begin
         y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
      end else if (y_wide < Y_MIN) begin
         y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         y_sat = y_wide[SAMPLE_WIDTH-1:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && (!bypass || out_free);
   assign req_fire  = req_valid && req_ready;

   // Sequencer: bypass, or two feedback products, w0, three feed-forward products, then output.
   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      start_in     = 1'b0;
      acc_in       = acc_ff;
      x_in         = x_ff;
      w0_in        = w0_ff;
      delay_one_in = delay_one_ff;
      delay_two_in = delay_two_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (bypass) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = req_sample_in;
               end else begin
                  x_in     = req_sample_in;
                  acc_in   = '0;
                  prod_in  = PROD_A1W1;
                  start_in = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               acc_in = acc_sum;
               if (prod_ff == PROD_A2W2) begin
                  state_in = S_ROUND_FB;
               end else if (prod_ff == PROD_B2W2) begin
                  state_in = S_ROUND_Y;
               end else begin
                  prod_in  = prod_ff + 1'b1;
                  start_in = 1'b1;
               end
            end
         end
         S_ROUND_FB: begin
            acc_in   = acc_sum;
            state_in = S_W0;
         end
         S_W0: begin
            w0_in    = w0_sat;
            acc_in   = '0;
            prod_in  = PROD_B0W0;
            start_in = 1'b1;
            state_in = S_MUL;
         end
         S_ROUND_Y: begin
            acc_in   = acc_sum;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_sat;
               delay_two_in = delay_one_ff;
               delay_one_in = w0_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prod_ff      <= PROD_A1W1;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else begin
         state_ff     <= state_in;
         prod_ff      <= prod_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      w0_ff       <= w0_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

`ifndef SYNTHESIS
   // A finished product only arrives while the sequencer waits for one.
   assert property (@(posedge clock) disable iff (reset) mul_done |-> (state_ff == S_MUL))
      else $error("multiplier finished outside the multiply state");

   // A bypassed transaction shows its own sample on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && bypass)
      |=> (rsp_valid && (rsp_sample_out == $past(req_sample_in))))
      else $error("bypassed sample not passed through");

   // Delay words move only when a filtered transaction completes.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> ($stable(delay_one_ff) && $stable(delay_two_ff)))
      else $error("delay words changed outside the output step");
`endif

endmodule
